FILE: hdl/lpfq_pkg.sv
// ============================================================================
// Length-prefixed frame ring queue package
// Shared sizes, function and status codes, the sequencer state type and
// the pointer and counter helpers.
// ============================================================================
package lpfq_pkg;

   localparam int QUEUE_DEPTH = 8192;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;
   localparam int LEN_W       = 16;
   localparam int DATA_W      = 8;
   localparam int SUM_W       = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
   localparam int HDR_BYTES   = 2;

   localparam logic [1:0] FUNC_BEGIN = 2'd0;
   localparam logic [1:0] FUNC_DATA  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_SEQUENCE = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_HDR     = 5'b00010,
      ST_RD_HI   = 5'b00100,
      ST_RD_LO   = 5'b01000,
      ST_RD_DATA = 5'b10000
   } state_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + PTR_W'(1);
      end
      return result;
   endfunction

   function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] result;
      if (cnt != '0) begin
         result = cnt - CNT_W'(1);
      end else begin
         result = '0;
      end
      return result;
   endfunction

   function automatic logic [LEN_W-1:0] len_dec(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] result;
      if (len != '0) begin
         result = len - LEN_W'(1);
      end else begin
         result = '0;
      end
      return result;
   endfunction

endpackage

FILE: hdl/lpfq_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module lpfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/length_prefixed_frame_ring_queue_top.sv
// ============================================================================
// Length-prefixed frame ring queue
// Byte ring that stores frames as a two-byte big-endian length followed by
// the data bytes, written and read one byte per word.
// ============================================================================
// The request channel takes one word per operation: begin a frame with its
// length, store one data byte, or read one byte of the oldest committed
// frame. Every request word yields exactly one response word with a status
// and, for reads, the byte, the frame length and first and last marks.
// A begin goes on to ST_HDR since the two header bytes go through the single
// write port one after the other. A data byte, a rejected request and an
// empty read finish in ST_IDLE. A read inside a frame goes on to ST_RD_DATA,
// as memory reads are registered. A read that opens a frame steps through
// ST_RD_HI, ST_RD_LO and ST_RD_DATA, since the two header bytes and the
// first data byte are fetched one after the other through the single read
// port; for a zero-length frame it ends in ST_RD_LO. The response appears
// in the cycle after its result is known and sits in an output register.
// While that register is held by a stalled receiver, no new request word
// is taken. Reset empties the queue at once; the byte memory needs no
// clearing pass, as only bytes that were written are ever read back.
// ============================================================================
module length_prefixed_frame_ring_queue_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [lpfq_pkg::LEN_W-1:0]  req_frame_length,
   input  logic [lpfq_pkg::DATA_W-1:0] req_wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [lpfq_pkg::DATA_W-1:0] rsp_rd_data,
   output logic [lpfq_pkg::LEN_W-1:0]  rsp_rd_length,
   output logic                        rsp_rd_first,
   output logic                        rsp_rd_last
);

   import lpfq_pkg::*;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  committed_ff, committed_in;
   logic [LEN_W-1:0]  wr_remaining_ff, wr_remaining_in;
   logic              wr_open_ff, wr_open_in;
   logic [LEN_W-1:0]  rd_remaining_ff, rd_remaining_in;
   logic              rd_open_ff, rd_open_in;
   logic [LEN_W-1:0]  rd_frame_len_ff, rd_frame_len_in;
   logic [DATA_W-1:0] hdr_lo_ff, hdr_lo_in;
   logic [DATA_W-1:0] len_hi_ff, len_hi_in;
   logic              pend_first_ff, pend_first_in;
   logic              pend_last_ff, pend_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [LEN_W-1:0]  rsp_length_ff;
   logic              rsp_first_ff;
   logic              rsp_last_ff;

   logic              load_rsp;
   logic [1:0]        res_status;
   logic [DATA_W-1:0] res_data;
   logic [LEN_W-1:0]  res_length;
   logic              res_first;
   logic              res_last;

   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic              out_free;
   logic              req_accept;
   logic [SUM_W-1:0]  room_sum;
   logic [LEN_W-1:0]  rem_dec;
   logic [LEN_W-1:0]  hdr_len;

   lpfq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && (state_ff == ST_IDLE) && out_free;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign room_sum   = SUM_W'(used_ff) + SUM_W'(req_frame_length) + SUM_W'(1);
   assign hdr_len    = {len_hi_ff, ram_rd_data};

   always_comb begin
      state_in        = state_ff;
      wr_ptr_in       = wr_ptr_ff;
      rd_ptr_in       = rd_ptr_ff;
      used_in         = used_ff;
      committed_in    = committed_ff;
      wr_remaining_in = wr_remaining_ff;
      wr_open_in      = wr_open_ff;
      rd_remaining_in = rd_remaining_ff;
      rd_open_in      = rd_open_ff;
      rd_frame_len_in = rd_frame_len_ff;
      hdr_lo_in       = hdr_lo_ff;
      len_hi_in       = len_hi_ff;
      pend_first_in   = pend_first_ff;
      pend_last_in    = pend_last_ff;
      load_rsp        = 1'b0;
      res_status      = STATUS_OK;
      res_data        = '0;
      res_length      = '0;
      res_first       = 1'b0;
      res_last        = 1'b0;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = wr_ptr_ff;
      ram_wr_data     = '0;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = rd_ptr_ff;
      rem_dec         = len_dec(wr_remaining_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_BEGIN: begin
                     load_rsp = 1'b1;
                     if (wr_open_ff) begin
                        res_status = STATUS_SEQUENCE;
                     end else if (room_sum < SUM_W'(QUEUE_DEPTH)) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_data     = req_frame_length[LEN_W-1:DATA_W];
                        wr_ptr_in       = ptr_next(wr_ptr_ff);
                        hdr_lo_in       = req_frame_length[DATA_W-1:0];
                        used_in         = CNT_W'(room_sum + SUM_W'(1));
                        wr_remaining_in = req_frame_length;
                        if (req_frame_length == '0) begin
                           committed_in = CNT_W'(room_sum + SUM_W'(1));
                        end else begin
                           wr_open_in = 1'b1;
                        end
                        state_in = ST_HDR;
                     end else begin
                        res_status = STATUS_NO_ROOM;
                     end
                  end
                  FUNC_DATA: begin
                     load_rsp = 1'b1;
                     if (!wr_open_ff) begin
                        res_status = STATUS_SEQUENCE;
                     end else begin
                        ram_wr_en       = 1'b1;
                        ram_wr_data     = req_wr_data;
                        wr_ptr_in       = ptr_next(wr_ptr_ff);
                        wr_remaining_in = rem_dec;
                        if (rem_dec == '0) begin
                           wr_open_in   = 1'b0;
                           committed_in = used_ff;
                        end
                     end
                  end
                  FUNC_READ: begin
                     if (rd_open_ff) begin
                        ram_rd_en       = 1'b1;
                        rd_ptr_in       = ptr_next(rd_ptr_ff);
                        used_in         = cnt_dec(used_ff);
                        committed_in    = cnt_dec(committed_ff);
                        rd_remaining_in = len_dec(rd_remaining_ff);
                        pend_first_in   = 1'b0;
                        pend_last_in    = (len_dec(rd_remaining_ff) == '0);
                        if (len_dec(rd_remaining_ff) == '0) begin
                           rd_open_in = 1'b0;
                        end
                        state_in = ST_RD_DATA;
                     end else if (committed_ff > CNT_W'(HDR_BYTES)) begin
                        ram_rd_en    = 1'b1;
                        rd_ptr_in    = ptr_next(rd_ptr_ff);
                        used_in      = cnt_dec(used_ff);
                        committed_in = cnt_dec(committed_ff);
                        state_in     = ST_RD_HI;
                     end else begin
                        load_rsp   = 1'b1;
                        res_status = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     load_rsp   = 1'b1;
                     res_status = STATUS_SEQUENCE;
                  end
               endcase
            end
         end
         ST_HDR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = hdr_lo_ff;
            wr_ptr_in   = ptr_next(wr_ptr_ff);
            state_in    = ST_IDLE;
         end
         ST_RD_HI: begin
            len_hi_in    = ram_rd_data;
            ram_rd_en    = 1'b1;
            rd_ptr_in    = ptr_next(rd_ptr_ff);
            used_in      = cnt_dec(used_ff);
            committed_in = cnt_dec(committed_ff);
            state_in     = ST_RD_LO;
         end
         ST_RD_LO: begin
            rd_frame_len_in = hdr_len;
            if (hdr_len == '0) begin
               load_rsp   = 1'b1;
               res_first  = 1'b1;
               res_last   = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               ram_rd_en       = 1'b1;
               rd_ptr_in       = ptr_next(rd_ptr_ff);
               used_in         = cnt_dec(used_ff);
               committed_in    = cnt_dec(committed_ff);
               rd_remaining_in = hdr_len - LEN_W'(1);
               pend_first_in   = 1'b1;
               pend_last_in    = (hdr_len == LEN_W'(1));
               rd_open_in      = (hdr_len != LEN_W'(1));
               state_in        = ST_RD_DATA;
            end
         end
         ST_RD_DATA: begin
            load_rsp   = 1'b1;
            res_data   = ram_rd_data;
            res_length = rd_frame_len_ff;
            res_first  = pend_first_ff;
            res_last   = pend_last_ff;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         used_ff         <= '0;
         committed_ff    <= '0;
         wr_remaining_ff <= '0;
         wr_open_ff      <= 1'b0;
         rd_remaining_ff <= '0;
         rd_open_ff      <= 1'b0;
         rd_frame_len_ff <= '0;
         pend_first_ff   <= 1'b0;
         pend_last_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         used_ff         <= used_in;
         committed_ff    <= committed_in;
         wr_remaining_ff <= wr_remaining_in;
         wr_open_ff      <= wr_open_in;
         rd_remaining_ff <= rd_remaining_in;
         rd_open_ff      <= rd_open_in;
         rd_frame_len_ff <= rd_frame_len_in;
         pend_first_ff   <= pend_first_in;
         pend_last_ff    <= pend_last_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_lo_ff <= hdr_lo_in;
      len_hi_ff <= len_hi_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status;
         rsp_data_ff   <= res_data;
         rsp_length_ff <= res_length;
         rsp_first_ff  <= res_first;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_rd_data   = rsp_data_ff;
   assign rsp_rd_length = rsp_length_ff;
   assign rsp_rd_first  = rsp_first_ff;
   assign rsp_rd_last   = rsp_last_ff;

endmodule

FILE: tb/tb_length_prefixed_frame_ring_queue_top.sv
// ============================================================================
// Length-prefixed frame ring queue testbench
// A short table of directed words covers the queue's corner cases: empty
// reads, words out of sequence, zero-length frames and rejected begins.
// The table is followed by random frame traffic with noise mixed in. Every
// response word is checked field by field against the table's reply or a
// behavioral copy of the queue. Both channels idle at random except during
// one long stretch, the receiver holds off once for a long stretch, and the
// sender pauses once until every response has come.
// ============================================================================
`timescale 1ns / 100ps

module tb_length_prefixed_frame_ring_queue_top;

   import lpfq_pkg::*;

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         RANDOM_WORDS = 2000;
   localparam int         IDLE_PCT     = 26;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         STALL_LIMIT  = 4000;
   localparam int         TAIL_CYCLES  = 16;
   localparam int         ROW_COUNT    = 25;

   typedef struct packed {
      logic [1:0]        func;
      logic [LEN_W-1:0]  flen;
      logic [DATA_W-1:0] wdata;
   } frame_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  length;
      logic              first;
      logic              last;
   } frame_rsp_type;

   typedef struct packed {
      frame_req_type req;
      logic          typed;
      frame_rsp_type rsp;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b1, '{STATUS_EMPTY,    8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_DATA,   16'hffff, 8'hff}, 1'b1, '{STATUS_SEQUENCE, 8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_UNUSED, 16'hffff, 8'hff}, 1'b1, '{STATUS_SEQUENCE, 8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_BEGIN,  16'h0000, 8'hff}, 1'b1, '{STATUS_OK,       8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_READ,   16'hffff, 8'hff}, 1'b1, '{STATUS_EMPTY,    8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_BEGIN,  16'h0001, 8'h00}, 1'b1, '{STATUS_OK,       8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_BEGIN,  16'hffff, 8'h00}, 1'b1, '{STATUS_SEQUENCE, 8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_DATA,   16'h0000, 8'hff}, 1'b1, '{STATUS_OK,       8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b1, '{STATUS_OK,       8'h00, 16'h0000, 1'b1, 1'b1}},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b1, '{STATUS_OK,       8'hff, 16'h0001, 1'b1, 1'b1}},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b1, '{STATUS_EMPTY,    8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_BEGIN,  16'h0003, 8'h00}, 1'b0, '0},
      '{'{FUNC_DATA,   16'h0000, 8'h00}, 1'b0, '0},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b0, '0},
      '{'{FUNC_DATA,   16'h0000, 8'ha5}, 1'b0, '0},
      '{'{FUNC_DATA,   16'h0000, 8'h5a}, 1'b0, '0},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b0, '0},
      '{'{FUNC_BEGIN,  16'hffff, 8'h00}, 1'b1, '{STATUS_NO_ROOM,  8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b0, '0},
      '{'{FUNC_BEGIN,  16'd8191, 8'h00}, 1'b1, '{STATUS_NO_ROOM,  8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b0, '0},
      '{'{FUNC_READ,   16'h0000, 8'h00}, 1'b1, '{STATUS_EMPTY,    8'h00, 16'h0000, 1'b0, 1'b0}},
      '{'{FUNC_BEGIN,  16'h0002, 8'h00}, 1'b0, '0},
      '{'{FUNC_DATA,   16'h0000, 8'hff}, 1'b0, '0},
      '{'{FUNC_DATA,   16'h0000, 8'h00}, 1'b0, '0}
   };

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [1:0]        req_func         = FUNC_READ;
   logic [LEN_W-1:0]  req_frame_length = '0;
   logic [DATA_W-1:0] req_wr_data      = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [1:0]        rsp_status;
   logic [DATA_W-1:0] rsp_rd_data;
   logic [LEN_W-1:0]  rsp_rd_length;
   logic              rsp_rd_first;
   logic              rsp_rd_last;

   frame_rsp_type     awaited_replies [$];
   int                mismatches = 0;
   bit                gaps_on    = 1'b1;
   bit                hold_rsp   = 1'b0;
   int                hold_left  = 0;

   logic [DATA_W-1:0] ring_bytes [QUEUE_DEPTH];
   int                wr_ptr        = 0;
   int                rd_ptr        = 0;
   int                used_cnt      = 0;
   int                committed_cnt = 0;
   int                wr_left       = 0;
   int                rd_left       = 0;
   int                rd_len        = 0;
   bit                wr_open       = 1'b0;
   bit                rd_open       = 1'b0;

   length_prefixed_frame_ring_queue_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_frame_length (req_frame_length),
      .req_wr_data      (req_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_rd_data      (rsp_rd_data),
      .rsp_rd_length    (rsp_rd_length),
      .rsp_rd_first     (rsp_rd_first),
      .rsp_rd_last      (rsp_rd_last)
   );

   always #5 clock = ~clock;

   function automatic void ring_push(input logic [DATA_W-1:0] b);
      ring_bytes[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
   endfunction

   function automatic logic [DATA_W-1:0] ring_pop();
      logic [DATA_W-1:0] b;
      b = ring_bytes[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      if (used_cnt > 0) begin
         used_cnt--;
      end
      if (committed_cnt > 0) begin
         committed_cnt--;
      end
      return b;
   endfunction

   function automatic frame_rsp_type ring_step(input frame_req_type w);
      frame_rsp_type     r;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] lo;
      r = '0;
      r.status = STATUS_OK;
      case (w.func)
         FUNC_BEGIN: begin
            if (wr_open) begin
               r.status = STATUS_SEQUENCE;
            end else if (used_cnt + int'(w.flen) + 1 < QUEUE_DEPTH) begin
               ring_push(w.flen[15:8]);
               ring_push(w.flen[7:0]);
               used_cnt += int'(w.flen) + HDR_BYTES;
               wr_left = int'(w.flen);
               if (w.flen == '0) begin
                  committed_cnt = used_cnt;
               end else begin
                  wr_open = 1'b1;
               end
            end else begin
               r.status = STATUS_NO_ROOM;
            end
         end
         FUNC_DATA: begin
            if (!wr_open) begin
               r.status = STATUS_SEQUENCE;
            end else begin
               ring_push(w.wdata);
               if (wr_left > 0) begin
                  wr_left--;
               end
               if (wr_left == 0) begin
                  wr_open = 1'b0;
                  committed_cnt = used_cnt;
               end
            end
         end
         FUNC_READ: begin
            if (rd_open) begin
               r.data = ring_pop();
               r.length = LEN_W'(rd_len);
               if (rd_left > 0) begin
                  rd_left--;
               end
               if (rd_left == 0) begin
                  rd_open = 1'b0;
                  r.last = 1'b1;
               end
            end else if (committed_cnt > 2) begin
               hi = ring_pop();
               lo = ring_pop();
               rd_len = int'({hi, lo});
               r.length = {hi, lo};
               r.first = 1'b1;
               if (rd_len == 0) begin
                  r.last = 1'b1;
               end else begin
                  r.data = ring_pop();
                  rd_left = rd_len - 1;
                  if (rd_left == 0) begin
                     r.last = 1'b1;
                  end else begin
                     rd_open = 1'b1;
                  end
               end
            end else begin
               r.status = STATUS_EMPTY;
            end
         end
         default: begin
            r.status = STATUS_SEQUENCE;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic send_word(input frame_req_type w, input logic typed,
                            input frame_rsp_type fixed);
      frame_rsp_type predicted;
      while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= w.func;
      req_frame_length <= w.flen;
      req_wr_data      <= w.wdata;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = ring_step(w);
      awaited_replies.push_back(typed ? fixed : predicted);
   endtask

   task automatic wait_replies_done();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (awaited_replies.size() != 0);
   endtask

   always @(posedge clock) begin : reply_check
      frame_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch("response word arrived with none awaited");
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            end
            if (rsp_rd_data !== want.data) begin
               report_mismatch($sformatf("rd_data %0h, expected %0h", rsp_rd_data, want.data));
            end
            if (rsp_rd_length !== want.length) begin
               report_mismatch($sformatf("rd_length %0d, expected %0d",
                                         rsp_rd_length, want.length));
            end
            if (rsp_rd_first !== want.first) begin
               report_mismatch($sformatf("rd_first %0b, expected %0b", rsp_rd_first, want.first));
            end
            if (rsp_rd_last !== want.last) begin
               report_mismatch($sformatf("rd_last %0b, expected %0b", rsp_rd_last, want.last));
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_rsp) begin
         hold_rsp = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      frame_req_type w;
      int            pick;
      int            size_pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ROW_COUNT; i++) begin
         send_word(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
      end
      wait_replies_done();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS / 4) begin
            hold_rsp = 1'b1;
         end
         if (n == RANDOM_WORDS / 2) begin
            wait_replies_done();
         end
         if (n == (RANDOM_WORDS * 3) / 4) begin
            gaps_on = 1'b0;
         end
         if (n == (RANDOM_WORDS * 7) / 8) begin
            gaps_on = 1'b1;
         end
         w.func  = FUNC_READ;
         w.flen  = LEN_W'($urandom_range(0, 16'hffff));
         w.wdata = DATA_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (wr_open) begin
            if (pick < 70) begin
               w.func = FUNC_DATA;
            end else if (pick < 92) begin
               w.func = FUNC_READ;
            end else if (pick < 96) begin
               w.func = FUNC_BEGIN;
            end else begin
               w.func = FUNC_UNUSED;
            end
         end else if (pick < 38) begin
            w.func = FUNC_BEGIN;
            size_pick = $urandom_range(0, 99);
            if (size_pick < 70) begin
               w.flen = LEN_W'($urandom_range(0, 8));
            end else if (size_pick < 95) begin
               w.flen = LEN_W'($urandom_range(9, 64));
            end else begin
               w.flen = LEN_W'($urandom_range(65, 600));
            end
         end else if (pick < 85) begin
            w.func = FUNC_READ;
         end else if (pick < 92) begin
            w.func = FUNC_BEGIN;
         end else if (pick < 96) begin
            w.func = FUNC_DATA;
         end else begin
            w.func = FUNC_UNUSED;
         end
         send_word(w, 1'b0, '0);
      end

      wait_replies_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: length_prefixed_frame_ring_queue_top.f
hdl/lpfq_pkg.sv
hdl/lpfq_ram.sv
hdl/length_prefixed_frame_ring_queue_top.sv
tb/tb_length_prefixed_frame_ring_queue_top.sv
